@@ design/bdd_pkg.sv @@
// ----------------------------------------------------------------------------
// bdd_pkg: shared types and constants for the binary disk dilation block
// Store geometry, field widths, register indexes, operation codes and the
// pixel address map used by the scan logic.
// ----------------------------------------------------------------------------
package bdd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_WEIGHT = 31;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int POS_W    = 10;
   localparam int DIM_W    = 11;
   localparam int WEIGHT_W = 5;
   localparam int SPAN_W   = WEIGHT_W;
   localparam int RAD_W    = WEIGHT_W - 1;
   localparam int OFF_W    = WEIGHT_W + 1;
   localparam int NBR_W    = DIM_W + 1;
   localparam int WSQ_W    = 2 * WEIGHT_W;
   localparam int DSQ_W    = 2 * OFF_W;
   localparam int IDX_W    = 2;
   localparam int CSR_W    = DIM_W;

   localparam int DIM_MAX_INT    = (1 << DIM_W) - 1;
   localparam int WEIGHT_MAX_INT = (1 << WEIGHT_W) - 1;
   localparam int WIDTH_CAP_INT  = (MAX_WIDTH < DIM_MAX_INT) ? MAX_WIDTH : DIM_MAX_INT;
   localparam int HEIGHT_CAP_INT = (MAX_HEIGHT < DIM_MAX_INT) ? MAX_HEIGHT : DIM_MAX_INT;
   localparam int WEIGHT_CAP_INT = (MAX_WEIGHT < WEIGHT_MAX_INT) ? MAX_WEIGHT : WEIGHT_MAX_INT;

   localparam logic [DIM_W-1:0]    WIDTH_CAP  = DIM_W'(WIDTH_CAP_INT);
   localparam logic [DIM_W-1:0]    HEIGHT_CAP = DIM_W'(HEIGHT_CAP_INT);
   localparam logic [WEIGHT_W-1:0] WEIGHT_CAP = WEIGHT_W'(WEIGHT_CAP_INT);

   localparam logic [DIM_W-1:0]    WIDTH_RESET  = DIM_W'(1024);
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = DIM_W'(1024);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(2);

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] REG_STROKE_WEIGHT = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [WEIGHT_W-1:0] weight;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic              data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic valid;
      logic pixel;
   } result_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic [DIM_W-1:0] x,
                                                    input logic [DIM_W-1:0] y);
      return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   endfunction

endpackage

@@ design/binary_disk_dilation.sv @@
// ----------------------------------------------------------------------------
// binary_disk_dilation: binary dilation of a stored bitmap with a disk
// Load words store one pixel in a bit-per-pixel frame store; query words
// return the dilated pixel at the addressed position.
//
//   channel   ports              direction   word
//   req       req_valid/ready    in          op, pos_x, pos_y, pixel_in
//   rsp       rsp_valid/ready    out         pixel_out
//   csr       csr_wen            in          csr_index, csr_wdata
//
// A query walks the neighbours of the disk in turn, bounded by the single
// read port of the frame store (one neighbour per cycle); it ends early on
// the first on neighbour.
// Reset is synchronous and active high; the frame store is not cleared.
// The result register holds a finished word, so the next item is taken
// while the previous result waits.
// ----------------------------------------------------------------------------
module binary_disk_dilation (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [bdd_pkg::POS_W-1:0]     req_pos_x,
   input  logic [bdd_pkg::POS_W-1:0]     req_pos_y,
   input  logic                          req_pixel_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pixel_out,
   input  logic                          csr_wen,
   input  logic [bdd_pkg::IDX_W-1:0]     csr_index,
   input  logic [bdd_pkg::CSR_W-1:0]     csr_wdata
);

   logic [bdd_pkg::DIM_W-1:0]    width_ff, width_in, height_ff, height_in;
   logic [bdd_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic                         rsp_valid_ff, rsp_valid_in, rsp_pixel_ff, rsp_pixel_in;

   bdd_pkg::cfg_type     cfg;
   bdd_pkg::ram_wr_type  ram_wr;
   bdd_pkg::ram_rd_type  ram_rd;
   bdd_pkg::result_type  result;
   logic [0:0]           ram_rdata;
   logic                 result_take;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      weight_in = weight_ff;
      if (csr_wen) begin
         case (csr_index)
            bdd_pkg::REG_IMAGE_WIDTH:   width_in  = csr_wdata;
            bdd_pkg::REG_IMAGE_HEIGHT:  height_in = csr_wdata;
            bdd_pkg::REG_STROKE_WEIGHT: weight_in = csr_wdata[bdd_pkg::WEIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp to the store geometry and largest disk
   assign cfg.width  = (width_ff > bdd_pkg::WIDTH_CAP) ? bdd_pkg::WIDTH_CAP : width_ff;
   assign cfg.height = (height_ff > bdd_pkg::HEIGHT_CAP) ? bdd_pkg::HEIGHT_CAP : height_ff;
   assign cfg.weight = (weight_ff > bdd_pkg::WEIGHT_CAP) ? bdd_pkg::WEIGHT_CAP : weight_ff;

   assign result_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid && result_take) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = result.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bdd_pkg::WIDTH_RESET;
         height_ff    <= bdd_pkg::HEIGHT_RESET;
         weight_ff    <= bdd_pkg::WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   bdd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pixel_in (req_pixel_in),
      .cfg          (cfg),
      .ram_wr       (ram_wr),
      .ram_rd       (ram_rd),
      .ram_rdata    (ram_rdata[0]),
      .result       (result),
      .result_take  (result_take)
   );

   bdd_ram #(
      .DATA_W (1),
      .DEPTH  (bdd_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (ram_rd.en),
      .rd_addr (ram_rd.addr),
      .rd_data (ram_rdata)
   );

endmodule

@@ design/bdd_ram.sv @@
// ----------------------------------------------------------------------------
// bdd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdd_ram #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bdd_core.sv @@
// ----------------------------------------------------------------------------
// bdd_core: load and neighbourhood scan sequencer
// Writes loaded pixels to the frame store; for a query walks the disk one
// neighbour per cycle, reads the store and stops on the first on pixel.
// ----------------------------------------------------------------------------
module bdd_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [bdd_pkg::POS_W-1:0]   req_pos_x,
   input  logic [bdd_pkg::POS_W-1:0]   req_pos_y,
   input  logic                        req_pixel_in,
   input  bdd_pkg::cfg_type            cfg,
   output bdd_pkg::ram_wr_type         ram_wr,
   output bdd_pkg::ram_rd_type         ram_rd,
   input  logic                        ram_rdata,
   output bdd_pkg::result_type         result,
   input  logic                        result_take
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [bdd_pkg::POS_W-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [bdd_pkg::RAD_W-1:0]    rad_ff, rad_in;
   logic [bdd_pkg::SPAN_W-1:0]   span_ff, span_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [bdd_pkg::WSQ_W-1:0]    wsq_ff, wsq_in;
   logic                         issue_ff, issue_in, chk_ff, chk_in, fin_ff, fin_in;
   logic                         pixel_ff, pixel_in;

   logic                         accept, in_bounds, in_disk, in_image, last_pos;
   logic signed [bdd_pkg::OFF_W-1:0] dx, dy;
   logic signed [bdd_pkg::DSQ_W-1:0] dx2, dy2;
   logic [bdd_pkg::DSQ_W-1:0]        dsq;
   logic signed [bdd_pkg::NBR_W-1:0] nx, ny;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_bounds = ({1'b0, req_pos_x} < cfg.width) && ({1'b0, req_pos_y} < cfg.height);

   assign dx  = $signed({1'b0, ox_ff}) - $signed({2'b00, rad_ff});
   assign dy  = $signed({1'b0, oy_ff}) - $signed({2'b00, rad_ff});
   assign dx2 = dx * dx;
   assign dy2 = dy * dy;
   assign dsq = $unsigned(dx2) + $unsigned(dy2);
   assign in_disk = {dsq, 2'b00} <= (bdd_pkg::DSQ_W + 2)'(wsq_ff);

   assign nx = $signed({{(bdd_pkg::NBR_W - bdd_pkg::POS_W){1'b0}}, cx_ff})
               + bdd_pkg::NBR_W'(dx);
   assign ny = $signed({{(bdd_pkg::NBR_W - bdd_pkg::POS_W){1'b0}}, cy_ff})
               + bdd_pkg::NBR_W'(dy);
   assign in_image = !nx[bdd_pkg::NBR_W-1] && !ny[bdd_pkg::NBR_W-1]
                     && (nx[bdd_pkg::DIM_W-1:0] < cfg.width)
                     && (ny[bdd_pkg::DIM_W-1:0] < cfg.height);
   assign last_pos = (ox_ff == span_ff) && (oy_ff == span_ff);

   assign ram_wr.en   = accept && (req_op == bdd_pkg::OP_LOAD) && in_bounds;
   assign ram_wr.addr = bdd_pkg::store_addr({1'b0, req_pos_x}, {1'b0, req_pos_y});
   assign ram_wr.data = req_pixel_in;

   assign ram_rd.en   = (state_ff == ST_SCAN) && issue_ff;
   assign ram_rd.addr = bdd_pkg::store_addr(nx[bdd_pkg::DIM_W-1:0], ny[bdd_pkg::DIM_W-1:0]);

   assign result.valid = (state_ff == ST_DONE);
   assign result.pixel = pixel_ff;

   always_comb begin
      state_in = state_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rad_in   = rad_ff;
      span_in  = span_ff;
      wsq_in   = wsq_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      issue_in = issue_ff;
      pixel_in = pixel_ff;
      chk_in   = 1'b0;
      fin_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_in    = req_pos_x;
               cy_in    = req_pos_y;
               rad_in   = cfg.weight[bdd_pkg::WEIGHT_W-1:1];
               span_in  = {cfg.weight[bdd_pkg::WEIGHT_W-1:1], 1'b0};
               wsq_in   = bdd_pkg::WSQ_W'(cfg.weight) * bdd_pkg::WSQ_W'(cfg.weight);
               ox_in    = '0;
               oy_in    = '0;
               issue_in = 1'b1;
               pixel_in = 1'b0;
               if ((req_op == bdd_pkg::OP_QUERY) && in_bounds) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               chk_in = in_disk && in_image;
               fin_in = last_pos;
               if (last_pos) begin
                  issue_in = 1'b0;
               end else if (ox_ff == span_ff) begin
                  ox_in = '0;
                  oy_in = oy_ff + 1'b1;
               end else begin
                  ox_in = ox_ff + 1'b1;
               end
            end
            if (chk_ff && ram_rdata) begin
               pixel_in = 1'b1;
               state_in = ST_DONE;
            end else if (fin_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= 1'b0;
         chk_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         chk_ff   <= chk_in;
         fin_ff   <= fin_in;
      end
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rad_ff   <= rad_in;
      span_ff  <= span_in;
      wsq_ff   <= wsq_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      pixel_ff <= pixel_in;
   end

endmodule

@@ tb/bdd_dilation_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdd_dilation_checker: result prediction and comparison for the dilation block
// Follows register writes and accepted request words, keeps its own copy of
// the frame store and the image settings, works out the pixel each word must
// return and compares the returned words against them in order.
// ----------------------------------------------------------------------------
module bdd_dilation_checker
   import bdd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_op,
   input  logic [POS_W-1:0] req_pos_x,
   input  logic [POS_W-1:0] req_pos_y,
   input  logic             req_pixel_in,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             rsp_pixel_out,
   input  logic             csr_wen,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               mismatches,
   output int               waiting,
   output int               lit_results
);

   logic [DIM_W-1:0]    img_width;
   logic [DIM_W-1:0]    img_height;
   logic [WEIGHT_W-1:0] img_weight;
   bit                  frame_bits [int unsigned];
   logic                expected_pixels [$];
   logic                want;
   int                  px;
   int                  py;

   initial begin
      mismatches  = 0;
      waiting     = 0;
      lit_results = 0;
   end

   function automatic int clip_dim(input logic [DIM_W-1:0] v, input int cap);
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   function automatic logic dilate_at(input int x, input int y);
      int          w;
      int          r;
      int          ew;
      int          eh;
      int          nx;
      int          ny;
      int unsigned a;
      logic        hit;
      w   = (int'(img_weight) > MAX_WEIGHT) ? MAX_WEIGHT : int'(img_weight);
      r   = w / 2;
      ew  = clip_dim(img_width, MAX_WIDTH);
      eh  = clip_dim(img_height, MAX_HEIGHT);
      hit = 1'b0;
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            nx = x + dx;
            ny = y + dy;
            if (4 * (dx * dx + dy * dy) <= w * w && nx >= 0 && ny >= 0 && nx < ew && ny < eh) begin
               a = ny * MAX_WIDTH + nx;
               if (frame_bits.exists(a) && frame_bits[a])
                  hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   task automatic flag(input string what, input logic want_px, input logic got_px);
      if (mismatches < 10)
         $display("%0t: %s: expected pixel_out %0b, got %0b", $time, what, want_px, got_px);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         img_width  <= WIDTH_RESET;
         img_height <= HEIGHT_RESET;
         img_weight <= WEIGHT_RESET;
         expected_pixels.delete();
         waiting <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               flag("result word with nothing outstanding", 1'bx, rsp_pixel_out);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want)
                  flag("pixel_out mismatch", want, rsp_pixel_out);
               else if (want)
                  lit_results++;
            end
         end
         if (req_valid && req_ready) begin
            px = int'(req_pos_x);
            py = int'(req_pos_y);
            if (px < clip_dim(img_width, MAX_WIDTH) && py < clip_dim(img_height, MAX_HEIGHT)) begin
               if (req_op == OP_LOAD)
                  frame_bits[py * MAX_WIDTH + px] = req_pixel_in;
               expected_pixels.push_back((req_op == OP_QUERY) ? dilate_at(px, py) : 1'b0);
            end else begin
               expected_pixels.push_back(1'b0);
            end
         end
         if (csr_wen) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  img_width <= csr_wdata[DIM_W-1:0];
               end
               REG_IMAGE_HEIGHT: begin
                  img_height <= csr_wdata[DIM_W-1:0];
               end
               REG_STROKE_WEIGHT: begin
                  img_weight <= csr_wdata[WEIGHT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         waiting <= expected_pixels.size();
      end
   end

endmodule

@@ tb/binary_disk_dilation_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_disk_dilation_tb: stimulus and verdict for the dilation block
// Loads pixels and queries dilated pixels under a series of image sizes and
// disk weights, from empty and oversized images to the widest disk. Every
// query reads only neighbours that were loaded beforehand. Both channels idle
// at random in two stretches and neither in a third; a checker predicts results.
// ----------------------------------------------------------------------------
module binary_disk_dilation_tb;
   import bdd_pkg::*;

   localparam int STALL_LIMIT  = 20000;
   localparam int RANDOM_WORDS = 560;
   localparam int IDLE_SPAN    = 215;
   localparam int DRAIN_CYCLES = 1000;

   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

   logic             clock         = 1'b0;
   logic             reset         = 1'b1;
   logic             req_valid     = 1'b0;
   logic             req_ready;
   logic             req_op        = OP_LOAD;
   logic [POS_W-1:0] req_pos_x     = '0;
   logic [POS_W-1:0] req_pos_y     = '0;
   logic             req_pixel_in  = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready     = 1'b0;
   logic             rsp_pixel_out;
   logic             csr_wen       = 1'b0;
   logic [IDX_W-1:0] csr_index     = '0;
   logic [CSR_W-1:0] csr_wdata     = '0;

   int mismatches;
   int waiting;
   int lit_results;

   int eff_w          = MAX_WIDTH;
   int eff_h          = MAX_HEIGHT;
   int radius         = 1;
   int words_counted  = 0;
   int loads_sent     = 0;
   int queries_sent   = 0;
   int settings_used  = 0;
   int send_idle_pct  = 15;
   int recv_idle_pct  = 66;
   int quiet_cycles   = 0;
   int first_random;

   binary_disk_dilation dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_pos_x, .req_pos_y, .req_pixel_in,
      .rsp_valid, .rsp_ready, .rsp_pixel_out,
      .csr_wen, .csr_index, .csr_wdata
   );

   bdd_dilation_checker dilation_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_pos_x, .req_pos_y, .req_pixel_in,
      .rsp_valid, .rsp_ready, .rsp_pixel_out,
      .csr_wen, .csr_index, .csr_wdata,
      .mismatches, .waiting, .lit_results
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wen)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic issue_word(input logic op, input int x, input int y, input logic pix);
      if (words_counted < IDLE_SPAN) begin
         send_idle_pct = 15;
         recv_idle_pct = 66;
      end else if (words_counted < 2 * IDLE_SPAN) begin
         send_idle_pct = 66;
         recv_idle_pct = 15;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_pos_x    <= POS_W'(x);
      req_pos_y    <= POS_W'(y);
      req_pixel_in <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_QUERY)
         queries_sent++;
      else if (x < eff_w && y < eff_h)
         loads_sent++;
      if (op == OP_QUERY || (x < eff_w && y < eff_h))
         words_counted++;
   endtask

   task automatic set_image(input int w, input int h, input int wt, input bit poke_unused);
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= CSR_W'(w);
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= CSR_W'(h);
      @(posedge clock);
      csr_index <= REG_STROKE_WEIGHT;
      csr_wdata <= (CSR_W'($urandom) << WEIGHT_W) | CSR_W'(wt);
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= CSR_W'($urandom);
         @(posedge clock);
      end
      csr_wen <= 1'b0;
      eff_w   = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eff_h   = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
      radius  = wt / 2;
      settings_used++;
   endtask

   function automatic int large_dim();
      case ($urandom_range(2))
         0: return 1024;
         1: return 2047;
         default: return $urandom_range(2047, 16);
      endcase
   endfunction

   function automatic int place_block(input int span, input int size);
      case ($urandom_range(2))
         0: return 0;
         1: return span - size;
         default: return $urandom_range(span - size);
      endcase
   endfunction

   task automatic random_image_run();
      int w;
      int h;
      int wt;
      int bw;
      int bh;
      int bx;
      int by;
      int xlo;
      int xhi;
      int ylo;
      int yhi;
      int density;
      int k;
      int x;
      int y;
      if ($urandom_range(99) < 65) begin
         w = $urandom_range(8, 1);
         h = $urandom_range(8, 1);
         if ($urandom_range(19) == 0) begin
            if ($urandom_range(1))
               w = 0;
            else
               h = 0;
         end
         wt = ($urandom_range(9) == 0) ? $urandom_range(31, 16) : $urandom_range(8);
      end else begin
         w  = large_dim();
         h  = large_dim();
         wt = $urandom_range(6);
      end
      set_image(w, h, wt, $urandom_range(3) == 0);
      case ($urandom_range(2))
         0: density = 5;
         1: density = 20;
         default: density = 50;
      endcase
      if (eff_w == 0 || eff_h == 0) begin
         bw = 0;
         bh = 0;
         bx = 0;
         by = 0;
      end else if (eff_w * eff_h <= 64) begin
         bw = eff_w;
         bh = eff_h;
         bx = 0;
         by = 0;
      end else begin
         bw = 2 * radius + $urandom_range(5, 2);
         bh = 2 * radius + $urandom_range(5, 2);
         bx = place_block(eff_w, bw);
         by = place_block(eff_h, bh);
      end
      // keep queries where every disk neighbour inside the image was loaded
      xlo = (bx == 0) ? 0 : bx + radius;
      xhi = (bx + bw == eff_w) ? eff_w - 1 : bx + bw - 1 - radius;
      ylo = (by == 0) ? 0 : by + radius;
      yhi = (by + bh == eff_h) ? eff_h - 1 : by + bh - 1 - radius;
      for (y = by; y < by + bh; y++) begin
         for (x = bx; x < bx + bw; x++)
            issue_word(OP_LOAD, x, y, $urandom_range(99) < density);
      end
      repeat ($urandom_range(45, 20)) begin
         k = $urandom_range(99);
         if ((bw == 0 || k < 10) && (eff_w < MAX_WIDTH || eff_h < MAX_HEIGHT)) begin
            x = $urandom_range(MAX_WIDTH - 1);
            y = $urandom_range(MAX_HEIGHT - 1);
            if (eff_w < MAX_WIDTH && ($urandom_range(1) || eff_h == MAX_HEIGHT))
               x = $urandom_range(MAX_WIDTH - 1, eff_w);
            else if (eff_h < MAX_HEIGHT)
               y = $urandom_range(MAX_HEIGHT - 1, eff_h);
            issue_word($urandom_range(1) ? OP_QUERY : OP_LOAD, x, y, 1'($urandom_range(1)));
         end else if (k < 55) begin
            issue_word(OP_QUERY, $urandom_range(xhi, xlo), $urandom_range(yhi, ylo),
                       1'($urandom_range(1)));
         end else if (k < 85) begin
            issue_word(OP_LOAD, $urandom_range(bx + bw - 1, bx), $urandom_range(by + bh - 1, by),
                       $urandom_range(99) < density);
         end else begin
            issue_word(OP_LOAD, $urandom_range(eff_w - 1), $urandom_range(eff_h - 1),
                       $urandom_range(99) < density);
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // far corner and near corner of the store, reset geometry
      issue_word(OP_LOAD, 1023, 1022, 1'b0);
      issue_word(OP_LOAD, 1022, 1023, 1'b0);
      issue_word(OP_LOAD, 1023, 1023, 1'b1);
      issue_word(OP_QUERY, 1023, 1023, 1'b1);
      issue_word(OP_LOAD, 0, 0, 1'b0);
      issue_word(OP_LOAD, 0, 1, 1'b0);
      issue_word(OP_LOAD, 1, 0, 1'b0);
      issue_word(OP_QUERY, 0, 0, 1'b0);
      issue_word(OP_LOAD, 1, 0, 1'b1);
      issue_word(OP_QUERY, 0, 0, 1'b0);

      // empty image, write to the unused register index
      set_image(0, 2047, 0, 1'b1);
      issue_word(OP_LOAD, 0, 0, 1'b1);
      issue_word(OP_QUERY, 0, 0, 1'b0);
      issue_word(OP_QUERY, 1023, 1023, 1'b1);

      // oversized image, single-pixel disk
      set_image(2047, 1025, 0, 1'b0);
      issue_word(OP_QUERY, 1023, 1023, 1'b0);
      issue_word(OP_QUERY, 0, 0, 1'b0);
      issue_word(OP_QUERY, 1, 0, 1'b1);

      // one-pixel image, widest disk
      set_image(1, 1, 31, 1'b0);
      issue_word(OP_QUERY, 0, 0, 1'b0);
      issue_word(OP_QUERY, 1, 0, 1'b0);
      issue_word(OP_LOAD, 0, 0, 1'b1);
      issue_word(OP_QUERY, 0, 0, 1'b0);
      issue_word(OP_QUERY, 0, 1023, 1'b1);

      first_random = words_counted;
      while (words_counted - first_random < RANDOM_WORDS)
         random_image_run();

      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d load words and %0d query words (%0d dilated on) over %0d image settings",
               loads_sent, queries_sent, lit_results, settings_used);
      $display("Images from empty to oversized, disk weights 0 to 31, idling on either side and none");
      if (mismatches == 0 && waiting == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
